FILE: hw/rtl/hb3_pkg.sv
package hb3_pkg;

  localparam int DEF_MAX_WIDTH = 2048;

  localparam int PIX_W  = 24;
  localparam int IMG_WW = 12;   // image_width register
  localparam int IMG_HW = 16;   // image_height register, also the row counters
  localparam int CFG_DW = 16;   // widest register
  localparam int CFG_IW = 1;

  localparam logic [CFG_IW-1:0] REG_IMAGE_WIDTH  = 1'b0;
  localparam logic [CFG_IW-1:0] REG_IMAGE_HEIGHT = 1'b1;

  localparam logic KIND_PIXEL = 1'b0;
  localparam logic KIND_DRAIN = 1'b1;

  localparam logic [PIX_W-1:0] PIX_WHITE = 24'hFF_FFFF;
  localparam logic [PIX_W-1:0] PIX_BLACK = 24'h00_0000;

endpackage

FILE: hw/rtl/hollow_black_regions_3x3_core.sv
// The transaction that causes a result is registered in stage 1, and the result in the output register;
// in stream terms results trail the pixels by one row plus one pixel, drains flush the rest.
// Throughput: while the output is not stalled, one transaction per cycle; one line-store read and one write-back
// per cycle, with the write of the previous pixel forwarded to a read of the same entry.
// Reset: counters, window and output valid clear, width 2048 and height 1; line store
// contents are not cleared and are only read where they were written.
module hollow_black_regions_3x3_core #(
  parameter int MAX_WIDTH = hb3_pkg::DEF_MAX_WIDTH
) (
  input  logic                       clk,
  input  logic                       rst,
  // slave side
  input  logic                       s_tvalid,
  output logic                       s_tready,
  input  logic [hb3_pkg::PIX_W-1:0]  s_tdata,   // in_red[7:0], in_green[15:8], in_blue[23:16]
  input  logic                       s_tuser,   // kind
  // master side
  output logic                       m_tvalid,
  input  logic                       m_tready,
  output logic [hb3_pkg::PIX_W-1:0]  m_tdata,   // out_red[7:0], out_green[15:8], out_blue[23:16]
  output logic                       m_tlast,   // frame_end
  // configuration
  input  logic                       cfg_we,
  input  logic [hb3_pkg::CFG_IW-1:0] cfg_index,
  input  logic [hb3_pkg::CFG_DW-1:0] cfg_data
);

  localparam int AW = $clog2(MAX_WIDTH);
  localparam int CW = $clog2(MAX_WIDTH + 1);
  localparam int EW = (CW > hb3_pkg::IMG_WW) ? CW : hb3_pkg::IMG_WW;
  localparam int PW = $clog2(MAX_WIDTH + 2);
  localparam int HW = hb3_pkg::IMG_HW;
  localparam int DW = hb3_pkg::PIX_W;

  // configuration registers
  logic [hb3_pkg::IMG_WW-1:0] image_width;
  logic [HW-1:0]              image_height;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= hb3_pkg::IMG_WW'(2048);
      image_height <= HW'(1);
    end else if (cfg_we) begin
      unique case (cfg_index)
        hb3_pkg::REG_IMAGE_WIDTH:  image_width  <= cfg_data[hb3_pkg::IMG_WW-1:0];
        hb3_pkg::REG_IMAGE_HEIGHT: image_height <= cfg_data[HW-1:0];
        default: ;
      endcase
    end
  end

  // effective frame size
  logic [CW-1:0] w, wm1;
  logic [HW-1:0] h, hm1;

  always_comb begin
    if (image_width == '0)
      w = CW'(1);
    else if (EW'(image_width) > EW'(MAX_WIDTH))
      w = CW'(MAX_WIDTH);
    else
      w = CW'(image_width);
    h   = (image_height == '0) ? HW'(1) : image_height;
    wm1 = w - CW'(1);
    hm1 = h - HW'(1);
  end

  // ---------------------------------------------------------------- stage 0
  logic          adv, accept;
  logic [AW-1:0] in_column, out_column;
  logic [HW-1:0] in_row, out_row;
  logic [PW-1:0] pending;

  logic [AW-1:0] in_col_n, out_col_n, in_column_next, out_column_next, rd_addr;
  logic [HW-1:0] in_row_n, out_row_n, in_row_next, out_row_next;
  logic [PW-1:0] pending_next;
  logic          is_pixel, emit, use_upper, interior, last_px;

  assign adv      = !m_tvalid || m_tready;
  assign s_tready = adv;
  assign accept   = s_tvalid && adv;
  assign is_pixel = (s_tuser == hb3_pkg::KIND_PIXEL);

  always_comb begin
    // counters beyond the current size restart at zero
    in_col_n  = (CW'(in_column)  >= w) ? '0 : in_column;
    out_col_n = (CW'(out_column) >= w) ? '0 : out_column;
    in_row_n  = (in_row  >= h) ? '0 : in_row;
    out_row_n = (out_row >= h) ? '0 : out_row;

    use_upper = (pending >= PW'(w) + PW'(1));
    if (is_pixel)
      emit = (pending > PW'(w));
    else
      emit = (in_col_n == '0) && (in_row_n == '0) && (pending != '0);

    interior = (out_row_n != '0) && (out_row_n < hm1) &&
               (out_col_n != '0) && (CW'(out_col_n) < wm1);
    last_px  = (out_row_n == hm1) && (CW'(out_col_n) == wm1);

    in_column_next = in_col_n;
    in_row_next    = in_row_n;
    if (is_pixel) begin
      if (CW'(in_col_n) == wm1) begin
        in_column_next = '0;
        in_row_next    = (in_row_n == hm1) ? '0 : in_row_n + HW'(1);
      end else begin
        in_column_next = in_col_n + AW'(1);
      end
    end

    out_column_next = out_col_n;
    out_row_next    = out_row_n;
    if (emit) begin
      if (CW'(out_col_n) == wm1) begin
        out_column_next = '0;
        out_row_next    = (out_row_n == hm1) ? '0 : out_row_n + HW'(1);
      end else begin
        out_column_next = out_col_n + AW'(1);
      end
    end

    pending_next = pending;
    if (is_pixel && !emit)
      pending_next = pending + PW'(1);
    else if (!is_pixel && emit)
      pending_next = pending - PW'(1);

    rd_addr = is_pixel ? in_col_n : out_col_n;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_column  <= '0;
      in_row     <= '0;
      out_column <= '0;
      out_row    <= '0;
      pending    <= '0;
    end else if (accept) begin
      in_column  <= in_column_next;
      in_row     <= in_row_next;
      out_column <= out_column_next;
      out_row    <= out_row_next;
      pending    <= pending_next;
    end
  end

  // stage 1 control and payload
  logic          s1_valid, s1_pixel, s1_emit, s1_upper, s1_interior, s1_last;
  logic [AW-1:0] s1_addr;
  logic [DW-1:0] s1_px;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (adv) begin
      s1_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_pixel    <= is_pixel;
      s1_emit     <= emit;
      s1_upper    <= use_upper;
      s1_interior <= interior;
      s1_last     <= last_px;
      s1_addr     <= rd_addr;
      s1_px       <= s_tdata;
    end
  end

  // ---------------------------------------------------------------- line store
  // upper row in the high half, middle row in the low half
  logic [2*DW-1:0] line_mem [MAX_WIDTH];
  logic [2*DW-1:0] rd_data, fwd_data, mem_q, wr_data;
  logic            fwd, wr_en;
  logic [DW-1:0]   mem_up, mem_mid;

  assign mem_q   = fwd ? fwd_data : rd_data;
  assign mem_up  = mem_q[2*DW-1:DW];
  assign mem_mid = mem_q[DW-1:0];
  assign wr_en   = adv && s1_valid && s1_pixel;
  assign wr_data = {mem_mid, s1_px};

  always_ff @(posedge clk) begin
    if (wr_en)
      line_mem[s1_addr] <= wr_data;
    if (adv)
      rd_data <= line_mem[rd_addr];
  end

  // a write in the read cycle to the same entry is not seen by the read
  always_ff @(posedge clk) begin
    if (rst) begin
      fwd <= 1'b0;
    end else if (adv) begin
      fwd <= wr_en && (s1_addr == rd_addr);
    end
  end

  always_ff @(posedge clk) begin
    if (adv)
      fwd_data <= wr_data;
  end

  // ---------------------------------------------------------------- window
  // columns 1 and 2 of the 3x3 window; column 0 is the incoming memory word and pixel
  logic [DW-1:0] w01, w02, w11, w12, w21, w22;

  always_ff @(posedge clk) begin
    if (rst) begin
      w01 <= '0;
      w02 <= '0;
      w11 <= '0;
      w12 <= '0;
      w21 <= '0;
      w22 <= '0;
    end else if (wr_en) begin
      w01 <= w02;
      w02 <= mem_up;
      w11 <= w12;
      w12 <= mem_mid;
      w21 <= w22;
      w22 <= s1_px;
    end
  end

  logic          nbrs_black;
  logic [DW-1:0] result;

  always_comb begin
    nbrs_black = (w01 == hb3_pkg::PIX_BLACK) && (w02 == hb3_pkg::PIX_BLACK) &&
                 (mem_up == hb3_pkg::PIX_BLACK) && (w11 == hb3_pkg::PIX_BLACK) &&
                 (mem_mid == hb3_pkg::PIX_BLACK) && (w21 == hb3_pkg::PIX_BLACK) &&
                 (w22 == hb3_pkg::PIX_BLACK) && (s1_px == hb3_pkg::PIX_BLACK);
    if (s1_pixel)
      result = (s1_interior && nbrs_black) ? hb3_pkg::PIX_WHITE : w12;
    else
      result = s1_upper ? mem_up : mem_mid;
  end

  // ---------------------------------------------------------------- output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (adv) begin
      m_tvalid <= s1_valid && s1_emit;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m_tdata <= result;
      m_tlast <= s1_last;
    end
  end

endmodule
